// ===== sv/lcm_pkg.sv =====
`default_nettype none
package lcm_pkg;

	// access kinds
	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_STORE = 2'd1;
	localparam logic [1:0] KIND_FETCH = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
	localparam logic [1:0] REG_SET_BITS    = 2'd1;
	localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;

	localparam logic [3:0] OFFSET_BITS_RST = 4'd4;
	localparam logic [3:0] SET_BITS_RST    = 4'd8;
	localparam logic [3:0] WAYS_IN_USE_RST = 4'd1;

	// statistics counter slots
	localparam int CNT_DATA_ACC  = 0;
	localparam int CNT_DATA_MISS = 1;
	localparam int CNT_DATA_REPL = 2;
	localparam int CNT_INST_ACC  = 3;
	localparam int CNT_INST_MISS = 4;
	localparam int CNT_INST_REPL = 5;
	localparam int CNT_FETCH     = 6;
	localparam int CNT_WB        = 7;
	localparam int NUM_CNT       = 8;

	localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

	// controller to datapath
	typedef struct packed {
		logic clear;   // clear one row of line state
		logic rd;      // input transaction accepted, read its set
		logic upd;     // apply the update and load the result
	} lcm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
	} lcm_status_t;

	function automatic logic [31:0] sat_add(input logic [31:0] v, input logic [31:0] a);
		logic [32:0] s;
		s = {1'b0, v} + {1'b0, a};
		return s[32] ? CNT_MAX : s[31:0];
	endfunction

endpackage
`default_nettype wire

// ===== sv/lcm_if.sv =====
`default_nettype none
interface lcm_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] address;

	modport source (output valid, output kind, output address, input ready);
	modport sink   (input valid, input kind, input address, output ready);
endinterface

interface lcm_out_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic        replaced;
	logic        copy_back;
	logic [31:0] data_accesses;
	logic [31:0] data_misses;
	logic [31:0] data_replacements;
	logic [31:0] inst_accesses;
	logic [31:0] inst_misses;
	logic [31:0] inst_replacements;
	logic [31:0] fetch_words;
	logic [31:0] writeback_words;

	modport source (output valid, output hit, output replaced, output copy_back,
		output data_accesses, output data_misses, output data_replacements,
		output inst_accesses, output inst_misses, output inst_replacements,
		output fetch_words, output writeback_words, input ready);
	modport sink (input valid, input hit, input replaced, input copy_back,
		input data_accesses, input data_misses, input data_replacements,
		input inst_accesses, input inst_misses, input inst_replacements,
		input fetch_words, input writeback_words, output ready);
endinterface
`default_nettype wire

// ===== sv/lcm_ctrl.sv =====
`default_nettype none
module lcm_ctrl
	import lcm_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  wire logic  out_ready,
	input  wire lcm_status_t status,
	output lcm_cmd_t   cmd
);

	localparam logic [1:0] ST_CLR  = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0] state_q;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// commands
	assign cmd.clear = (state_q == ST_CLR);
	assign cmd.rd    = accept;
	assign cmd.upd   = (state_q == ST_UPD) && out_free;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					if (status.clear_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_CLR;
			endcase
		end
	end

	// result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.upd) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	a_accept_to_upd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_UPD)
		else $error("accepted access did not enter update");

	a_upd_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) && !out_free |=> (state_q == ST_UPD) && out_valid_q)
		else $error("update left while result slot was full");

	a_clear_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) && !status.clear_last |=> (state_q == ST_CLR) && !in_ready)
		else $error("clearing pass ended early");

endmodule
`default_nettype wire

// ===== sv/lcm_dp.sv =====
`default_nettype none
module lcm_dp
	import lcm_pkg::*;
#(
	parameter int SETS      = 256,
	parameter int WAYS      = 8,
	parameter int ADDR_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [3:0]  cfg_data,
	input  wire lcm_cmd_t    cmd,
	output lcm_status_t      status,
	input  wire logic [1:0]  kind,
	input  wire logic [31:0] address,
	output logic             hit,
	output logic             replaced,
	output logic             copy_back,
	output logic [NUM_CNT-1:0][31:0] counters
);

	localparam int IDX_W  = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int AGE_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int NW_W   = $clog2(WAYS + 1);
	localparam int TAG_W  = ADDR_BITS - 2;
	localparam int MAX_SB = $clog2(SETS + 1) - 1;
	localparam logic [31:0] AMASK = 32'((64'd1 << ADDR_BITS) - 64'd1);
	localparam logic [AGE_W-1:0] AGE_TOP = AGE_W'(WAYS - 1);

	// configuration
	logic [3:0] offset_bits_q, set_bits_q, ways_in_use_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= OFFSET_BITS_RST;
			set_bits_q    <= SET_BITS_RST;
			ways_in_use_q <= WAYS_IN_USE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_OFFSET_BITS: offset_bits_q <= cfg_data;
				REG_SET_BITS:    set_bits_q    <= cfg_data;
				REG_WAYS_IN_USE: ways_in_use_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective split
	logic [3:0]      off_eff, sb_eff;
	logic [NW_W-1:0] nways;
	always_comb begin
		off_eff = (offset_bits_q < 4'd2) ? 4'd2 :
			((offset_bits_q > 4'd12) ? 4'd12 : offset_bits_q);
		sb_eff = (32'(set_bits_q) > MAX_SB) ? 4'(MAX_SB) : set_bits_q;
		if (ways_in_use_q == 4'd0) nways = NW_W'(1);
		else if (32'(ways_in_use_q) > WAYS) nways = NW_W'(WAYS);
		else nways = NW_W'(ways_in_use_q);
	end

	// set index of the incoming access
	logic [31:0]      addr_in_m, set_full;
	logic [IDX_W-1:0] set_in;
	assign addr_in_m = address & AMASK;
	assign set_full  = (addr_in_m >> off_eff) & ((32'd1 << sb_eff) - 32'd1);
	assign set_in    = set_full[IDX_W-1:0];

	// line state memories, one row per set
	logic [WAYS-1:0][TAG_W-1:0] tag_mem [SETS];
	logic [WAYS-1:0]            vld_mem [SETS];
	logic [WAYS-1:0]            drt_mem [SETS];
	logic [WAYS-1:0][AGE_W-1:0] age_mem [SETS];

	logic [WAYS-1:0][TAG_W-1:0] tag_rd_q;
	logic [WAYS-1:0]            vld_rd_q, drt_rd_q;
	logic [WAYS-1:0][AGE_W-1:0] age_rd_q;
	logic [WAYS-1:0][TAG_W-1:0] tag_wr;
	logic [WAYS-1:0]            vld_wr, drt_wr;
	logic [WAYS-1:0][AGE_W-1:0] age_wr;
	logic                       wr_en;

	logic [IDX_W-1:0] set_q, clr_idx_q;
	logic [1:0]       kind_q;
	logic [31:0]      addr_q;

	// latch the access
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			set_q  <= set_in;
			kind_q <= kind;
			addr_q <= addr_in_m;
		end
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clear) begin
			clr_idx_q <= clr_idx_q + IDX_W'(1);
		end
	end
	assign status.clear_last = (32'(clr_idx_q) == SETS - 1);

	// memory ports
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			tag_rd_q <= tag_mem[set_in];
			vld_rd_q <= vld_mem[set_in];
			drt_rd_q <= drt_mem[set_in];
			age_rd_q <= age_mem[set_in];
		end
		if (cmd.clear) begin
			vld_mem[clr_idx_q] <= '0;
			drt_mem[clr_idx_q] <= '0;
			age_mem[clr_idx_q] <= '0;
		end else if (wr_en) begin
			tag_mem[set_q] <= tag_wr;
			vld_mem[set_q] <= vld_wr;
			drt_mem[set_q] <= drt_wr;
			age_mem[set_q] <= age_wr;
		end
	end

	// lookup and replacement
	logic [31:0]      tag_full, words;
	logic [TAG_W-1:0] tag;
	logic             is_store, is_inst, live;
	logic             f_hit, f_inv, f_repl, f_cb;
	logic [AGE_W-1:0] limit, best_age;
	logic [AGE_W-1:0] w;

	always_comb begin
		tag_full = addr_q >> (5'(off_eff) + 5'(sb_eff));
		tag      = tag_full[TAG_W-1:0];
		words    = 32'd1 << (off_eff - 4'd2);
		is_store = (kind_q == KIND_STORE);
		is_inst  = (kind_q == KIND_FETCH);
		live     = (kind_q != KIND_NONE);
		f_hit = 1'b0;
		f_inv = 1'b0;
		f_repl = 1'b0;
		f_cb = 1'b0;
		w = '0;
		// first matching way
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (i < nways && vld_rd_q[i] && tag_rd_q[i] == tag) begin
				f_hit = 1'b1;
				w = AGE_W'(i);
			end
		end
		// first invalid way
		if (!f_hit) begin
			for (int i = WAYS - 1; i >= 0; i--) begin
				if (i < nways && !vld_rd_q[i]) begin
					f_inv = 1'b1;
					w = AGE_W'(i);
				end
			end
		end
		// oldest way, lowest index on a tie
		if (!f_hit && !f_inv) begin
			w = '0;
			best_age = age_rd_q[0];
			for (int i = 1; i < WAYS; i++) begin
				if (i < nways && age_rd_q[i] > best_age) begin
					best_age = age_rd_q[i];
					w = AGE_W'(i);
				end
			end
			f_repl = 1'b1;
			f_cb = drt_rd_q[w];
		end else begin
			best_age = '0;
		end
		limit = f_inv ? AGE_TOP : age_rd_q[w];

		// new row contents
		tag_wr = tag_rd_q;
		vld_wr = vld_rd_q;
		drt_wr = drt_rd_q;
		age_wr = age_rd_q;
		for (int i = 0; i < WAYS; i++) begin
			if (i < nways && i != w && vld_rd_q[i] && age_rd_q[i] < AGE_TOP &&
				(f_inv || age_rd_q[i] < limit)) begin
				age_wr[i] = age_rd_q[i] + AGE_W'(1);
			end
		end
		age_wr[w] = '0;
		if (f_hit) begin
			if (is_store) drt_wr[w] = 1'b1;
		end else begin
			tag_wr[w] = tag;
			vld_wr[w] = 1'b1;
			drt_wr[w] = is_store;
		end
		wr_en = cmd.upd && live;
	end

	// result flags
	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			hit       <= live && f_hit;
			replaced  <= live && f_repl;
			copy_back <= live && f_cb;
		end
	end

	// saturating statistics
	logic [NUM_CNT-1:0][31:0] cnt_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.upd && live) begin
			if (is_inst) begin
				cnt_q[CNT_INST_ACC] <= sat_add(cnt_q[CNT_INST_ACC], 32'd1);
				if (!f_hit) cnt_q[CNT_INST_MISS] <= sat_add(cnt_q[CNT_INST_MISS], 32'd1);
				if (f_repl) cnt_q[CNT_INST_REPL] <= sat_add(cnt_q[CNT_INST_REPL], 32'd1);
			end else begin
				cnt_q[CNT_DATA_ACC] <= sat_add(cnt_q[CNT_DATA_ACC], 32'd1);
				if (!f_hit) cnt_q[CNT_DATA_MISS] <= sat_add(cnt_q[CNT_DATA_MISS], 32'd1);
				if (f_repl) cnt_q[CNT_DATA_REPL] <= sat_add(cnt_q[CNT_DATA_REPL], 32'd1);
			end
			if (!f_hit) cnt_q[CNT_FETCH] <= sat_add(cnt_q[CNT_FETCH], words);
			if (f_cb)   cnt_q[CNT_WB]    <= sat_add(cnt_q[CNT_WB], words);
		end
	end
	assign counters = cnt_q;

endmodule
`default_nettype wire

// ===== sv/lru_cache_tag_model_core.sv =====
`default_nettype none
// channel  | role  | accepted when        | carries
// in_ch    | sink  | valid && ready       | kind, address
// out_ch   | source| valid && ready       | hit, replaced, copy_back, eight counters
// cfg      | write | cfg_we               | cfg_idx, cfg_data
//
// For each access the set row is read from the line-state memories on
// acceptance, then ages, tags and counters are written back.
// After reset a clearing pass, one memory row a cycle, runs before the first
// access is accepted; configuration writes are taken.
// A result waits in the output register; the next access is accepted while
// it waits and its update stalls until the result slot is free.
module lru_cache_tag_model_core
	import lcm_pkg::*;
#(
	parameter int SETS      = 256,
	parameter int WAYS      = 8,
	parameter int ADDR_BITS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_idx,
	input  wire logic [3:0] cfg_data,
	lcm_in_if.sink          in_ch,
	lcm_out_if.source       out_ch
);

	lcm_cmd_t    cmd;
	lcm_status_t status;
	logic [NUM_CNT-1:0][31:0] counters;

	lcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	lcm_dp #(
		.SETS      (SETS),
		.WAYS      (WAYS),
		.ADDR_BITS (ADDR_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.kind      (in_ch.kind),
		.address   (in_ch.address),
		.hit       (out_ch.hit),
		.replaced  (out_ch.replaced),
		.copy_back (out_ch.copy_back),
		.counters  (counters)
	);

	assign out_ch.data_accesses     = counters[CNT_DATA_ACC];
	assign out_ch.data_misses       = counters[CNT_DATA_MISS];
	assign out_ch.data_replacements = counters[CNT_DATA_REPL];
	assign out_ch.inst_accesses     = counters[CNT_INST_ACC];
	assign out_ch.inst_misses       = counters[CNT_INST_MISS];
	assign out_ch.inst_replacements = counters[CNT_INST_REPL];
	assign out_ch.fetch_words       = counters[CNT_FETCH];
	assign out_ch.writeback_words   = counters[CNT_WB];

endmodule
`default_nettype wire
